### hdl/hwtb_pkg.sv
`timescale 1ns / 1ps
package hwtb_pkg;

  localparam int PORTS     = 4;
  localparam int HW        = 16;            // Q8.8 height width
  localparam int WW        = 17;            // Q1.16 weight, 65536 is one
  localparam int PW        = WW + 8;        // weight times one channel
  localparam int CHAN_MAX  = 255;
  localparam int CH        = 3;

  localparam logic [2:0] REG_TILES  = 3'd0;
  localparam logic [2:0] REG_RANGE0 = 3'd1;

  // weight decided before the divider, or left to it
  typedef struct packed {
    logic zero;
    logic one;
  } lane_ctl_t;

endpackage

### hdl/height_weighted_tile_blend.sv
`timescale 1ns / 1ps
// The result strobe (done) follows the start cycle through
// setup, 16 divider stages (one quotient bit each), multiply, sum and clamp.
// Throughput: one pixel every cycle; busy stays low and the receiver cannot stall.
// Reset (rst, synchronous): clears the pipeline, tiles_in_use to 4, ranges to 0.
module height_weighted_tile_blend #(
  parameter int TILES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] terrain_height,
  input  logic [23:0] tile_0_color,
  input  logic [23:0] tile_1_color,
  input  logic [23:0] tile_2_color,
  input  logic [23:0] tile_3_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        done,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        color_overflow
);

  localparam int LANES = (TILES < hwtb_pkg::PORTS) ? TILES : hwtb_pkg::PORTS;

  logic [2:0]  tiles_in_use;
  logic [47:0] range [hwtb_pkg::PORTS];
  logic [23:0] color [hwtb_pkg::PORTS];
  logic [LANES-1:0] lane_valid;
  logic [hwtb_pkg::PW-1:0] prod [LANES][hwtb_pkg::CH];
  logic [7:0]  chan [hwtb_pkg::CH];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign color[0]  = tile_0_color;
  assign color[1]  = tile_1_color;
  assign color[2]  = tile_2_color;
  assign color[3]  = tile_3_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_in_use <= 3'd4;
      for (int i = 0; i < hwtb_pkg::PORTS; i++) begin
        range[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == hwtb_pkg::REG_TILES) begin
        tiles_in_use <= cfg_data[2:0];
      end
      for (int i = 0; i < hwtb_pkg::PORTS; i++) begin
        if (cfg_index == hwtb_pkg::REG_RANGE0 + 3'(i)) begin
          range[i] <= cfg_data;
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [hwtb_pkg::PW-1:0] lp [hwtb_pkg::CH];
    hwtb_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .start      (start),
      .en         (tiles_in_use > 3'(l)),
      .range      (range[l]),
      .height     (terrain_height),
      .texel      (color[l]),
      .prod_valid (lane_valid[l]),
      .prod       (lp)
    );
    always_comb begin
      for (int c = 0; c < hwtb_pkg::CH; c++) begin
        prod[l][c] = lp[c];
      end
    end
  end

  hwtb_merge #(.LANES(LANES)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lane_valid[0]),
    .prod     (prod),
    .done     (done),
    .chan     (chan),
    .ovf      (color_overflow)
  );

  assign out_red   = chan[0];
  assign out_green = chan[1];
  assign out_blue  = chan[2];

endmodule

### hdl/hwtb_lane.sv
`timescale 1ns / 1ps
module hwtb_lane (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        en,
  input  logic [47:0] range,
  input  logic [15:0] height,
  input  logic [23:0] texel,
  output logic        prod_valid,
  output logic [hwtb_pkg::PW-1:0] prod [hwtb_pkg::CH]
);

  localparam int STAGES = 16;

  logic signed [16:0] h, lo, pk, hi, nom, den;
  logic               outside;
  hwtb_pkg::lane_ctl_t ctl_next;

  logic [15:0]         rem   [STAGES+1];
  logic [15:0]         quo   [STAGES+1];
  logic [15:0]         dv    [STAGES+1];
  logic [23:0]         tex   [STAGES+1];
  hwtb_pkg::lane_ctl_t ctl   [STAGES+1];
  logic                vld   [STAGES+1];
  logic [hwtb_pkg::WW-1:0] weight;

  always_comb begin
    h  = {height[15], height};
    lo = {range[15], range[15:0]};
    pk = {range[31], range[31:16]};
    hi = {range[47], range[47:32]};
    outside = (h < lo) || (h > hi);
    if (h < pk) begin
      nom = h - lo;
      den = pk - lo;
    end else begin
      nom = hi - h;
      den = hi - pk;
    end
    ctl_next.zero = 1'b0;
    ctl_next.one  = 1'b0;
    if (!en || outside) begin
      ctl_next.zero = 1'b1;
    end else if (den == 17'sd0) begin
      ctl_next.one = 1'b1;
    end else if (den < 17'sd0 || nom < 17'sd0) begin
      ctl_next.zero = 1'b1;
    end else if (nom >= den) begin
      ctl_next.one = 1'b1;
    end
  end

  // stage 0: set up remainder and divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start;
    end
    rem[0] <= nom[15:0];
    quo[0] <= '0;
    dv[0]  <= den[15:0];
    tex[0] <= texel;
    ctl[0] <= ctl_next;
  end

  // one quotient bit per stage; remainder stays below the divisor
  always_ff @(posedge clk) begin
    for (int k = 1; k <= STAGES; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      if ({rem[k-1], 1'b0} >= {1'b0, dv[k-1]}) begin
        rem[k] <= 16'({rem[k-1], 1'b0} - {1'b0, dv[k-1]});
        quo[k] <= {quo[k-1][14:0], 1'b1};
      end else begin
        rem[k] <= {rem[k-1][14:0], 1'b0};
        quo[k] <= {quo[k-1][14:0], 1'b0};
      end
      dv[k]  <= dv[k-1];
      tex[k] <= tex[k-1];
      ctl[k] <= ctl[k-1];
    end
  end

  always_comb begin
    if (ctl[STAGES].zero) begin
      weight = '0;
    end else if (ctl[STAGES].one) begin
      weight = {1'b1, 16'd0};
    end else begin
      weight = {1'b0, quo[STAGES]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= vld[STAGES];
    end
    for (int c = 0; c < hwtb_pkg::CH; c++) begin
      prod[c] <= weight * tex[STAGES][8*c +: 8];
    end
  end

endmodule

### hdl/hwtb_merge.sv
`timescale 1ns / 1ps
module hwtb_merge #(
  parameter int LANES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [hwtb_pkg::PW-1:0] prod [LANES][hwtb_pkg::CH],
  output logic       done,
  output logic [7:0] chan [hwtb_pkg::CH],
  output logic       ovf
);

  localparam int SW = hwtb_pkg::PW + $clog2(LANES + 1);

  logic [SW-1:0]    sum  [hwtb_pkg::CH];
  logic [SW-17:0]   whole[hwtb_pkg::CH];
  logic [hwtb_pkg::CH-1:0] hit;

  always_comb begin
    for (int c = 0; c < hwtb_pkg::CH; c++) begin
      sum[c] = '0;
      for (int l = 0; l < LANES; l++) begin
        sum[c] = sum[c] + SW'(prod[l][c]);
      end
      whole[c] = sum[c][SW-1:16];
      hit[c]   = whole[c] >= (SW-16)'(hwtb_pkg::CHAN_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    for (int c = 0; c < hwtb_pkg::CH; c++) begin
      chan[c] <= hit[c] ? 8'(hwtb_pkg::CHAN_MAX) : whole[c][7:0];
    end
    ovf <= |hit;
  end

endmodule

### tb/sv/blend_checker.sv
`timescale 1ns / 1ps
module blend_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] terrain_height,
  input  logic [23:0]        tile_0_color,
  input  logic [23:0]        tile_1_color,
  input  logic [23:0]        tile_2_color,
  input  logic [23:0]        tile_3_color,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               done,
  input  logic [7:0]         out_red,
  input  logic [7:0]         out_green,
  input  logic [7:0]         out_blue,
  input  logic               color_overflow,
  output int                 fail_count,
  output int                 pixels_pending
);
  import hwtb_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       ovf;
  } pixel_t;

  logic [2:0]  tiles_in_use;
  logic [47:0] tile_range [PORTS];
  pixel_t      pixel_queue [$];

  function automatic logic [16:0] tile_weight(logic [47:0] rng, logic signed [15:0] h);
    int lo, pk, hi, nom, den;
    logic [47:0] q;
    lo = $signed(rng[15:0]);
    pk = $signed(rng[31:16]);
    hi = $signed(rng[47:32]);
    if (h < lo || h > hi) return 17'd0;
    if (h < pk) begin
      nom = h - lo;
      den = pk - lo;
    end else begin
      nom = hi - h;
      den = hi - pk;
    end
    if (den <= 0 || nom < 0) return (den == 0) ? 17'd65536 : 17'd0;
    if (nom >= den) return 17'd65536;
    q = (48'(nom) << 16) / 48'(den);
    return q[16:0];
  endfunction

  function automatic pixel_t blend_pixel(logic signed [15:0] h, logic [23:0] tex [PORTS]);
    longint unsigned acc [3];
    longint unsigned v;
    logic [16:0] w;
    int n;
    pixel_t p;
    acc = '{0, 0, 0};
    n = (tiles_in_use > PORTS) ? PORTS : tiles_in_use;
    for (int i = 0; i < n; i++) begin
      w = tile_weight(tile_range[i], h);
      for (int c = 0; c < 3; c++) acc[c] += w * tex[i][8*c +: 8];
    end
    p.ovf = 1'b0;
    for (int c = 0; c < 3; c++) begin
      v = acc[c] >> 16;
      if (v >= CHAN_MAX) begin
        p.ovf = 1'b1;
        v = CHAN_MAX;
      end
      if (c == 0) p.red = v[7:0];
      else if (c == 1) p.green = v[7:0];
      else p.blue = v[7:0];
    end
    return p;
  endfunction

  always @(posedge clk) begin
    logic [23:0] tex [PORTS];
    pixel_t got, want;
    if (rst) begin
      tiles_in_use <= 3'd4;
      for (int i = 0; i < PORTS; i++) tile_range[i] <= '0;
      pixel_queue.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        got = '{out_red, out_green, out_blue, color_overflow};
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected pixel %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_queue.pop_front();
          if (got !== want) begin
            $display("%0t: pixel expected r=%h g=%h b=%h ovf=%b, actual r=%h g=%h b=%h ovf=%b",
                     $time, want.red, want.green, want.blue, want.ovf,
                     got.red, got.green, got.blue, got.ovf);
            fail_count <= fail_count + 1;
          end
        end
      end
      // the item uses the register values from before a write in the same cycle
      if (start && !busy) begin
        tex = '{tile_0_color, tile_1_color, tile_2_color, tile_3_color};
        pixel_queue.push_back(blend_pixel(terrain_height, tex));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TILES) tiles_in_use <= cfg_data[2:0];
        else if (cfg_index >= REG_RANGE0 && cfg_index < REG_RANGE0 + PORTS)
          tile_range[cfg_index - REG_RANGE0] <= cfg_data;
      end
    end
    pixels_pending <= pixel_queue.size();
  end
endmodule

### tb/sv/tb_height_weighted_tile_blend.sv
`timescale 1ns / 1ps
module tb_height_weighted_tile_blend;
  import hwtb_pkg::*;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, color_overflow;
  logic signed [15:0] terrain_height;
  logic [23:0] tile_0_color, tile_1_color, tile_2_color, tile_3_color;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic [7:0]  out_red, out_green, out_blue;
  int fail_count, pixels_pending;
  int idle_pct;

  height_weighted_tile_blend i_dut (.*);
  blend_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [15:0] pick_height();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [47:0] pick_range();
    logic signed [15:0] a, b, c, t;
    a = 16'($urandom_range(0, 65535));
    b = 16'($urandom_range(0, 65535));
    c = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 4) != 0) begin
      // sort so most ranges are well formed
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
      if ($urandom_range(0, 5) == 0) b = c;
      if ($urandom_range(0, 5) == 0) b = a;
    end
    return {c, b, a};
  endfunction

  // drop valid and let the design sample it low before returning
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // leave start high on return so items can follow back to back
  task automatic send_pixel(logic [15:0] h, logic [23:0] c0, c1, c2, c3);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    terrain_height <= h;
    tile_0_color   <= c0;
    tile_1_color   <= c1;
    tile_2_color   <= c2;
    tile_3_color   <= c3;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pixels_pending != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic send_random();
    send_pixel(pick_height(), 24'($urandom_range(0, 24'hffffff)),
               24'($urandom_range(0, 24'hffffff)),
               24'($urandom_range(0, 24'hffffff)), 24'($urandom_range(0, 24'hffffff)));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    terrain_height = '0;
    {tile_0_color, tile_1_color, tile_2_color, tile_3_color} = '0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset ranges: all zero, weight one only at height zero
    send_pixel(16'h0000, 24'hffffff, 24'h010203, 24'h000000, 24'h808080);
    send_pixel(16'h0001, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    drain();
    write_reg(REG_RANGE0,         {16'h0200, 16'h0100, 16'h0000});
    write_reg(REG_RANGE0 + 3'd1, {16'h0300, 16'h0300, 16'h0100});
    write_reg(REG_RANGE0 + 3'd2, {16'h0000, 16'h0000, 16'h0100}); // inverted
    write_reg(REG_RANGE0 + 3'd3, {16'h7fff, 16'h0000, 16'h8000});
    write_reg(3'd5, 48'hffffffffffff);
    write_reg(3'd7, 48'h0);
    for (int i = 0; i < 8; i++)
      send_pixel(16'(i) * 16'h0080, 24'hffffff, 24'h7f7f7f, 24'hffffff, 24'h0000ff);
    send_pixel(16'h8000, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    send_pixel(16'h7fff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    drain();
    write_reg(REG_TILES, 48'd0);
    send_pixel(16'h0100, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    drain();
    write_reg(REG_TILES, 48'd7);
    send_pixel(16'h0300, 24'h123456, 24'hffffff, 24'hffffff, 24'hffffff);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      idle_pct = (phase < 4) ? 24 : (phase < 8) ? 81 : 0;
      write_reg(REG_TILES, (phase % 3 == 0) ? 48'd4 : 48'($urandom_range(0, 7)));
      for (int k = 0; k < PORTS; k++) write_reg(REG_RANGE0 + 3'(k), pick_range());
      for (int n = 0; n < 150; n++) send_random();
      drain();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
